// File: design/tsps_pkg.sv
// Shared types and constants for the song position sequencer.
// Used by the channel interfaces, the next-position logic and the top level.
package tsps_pkg;

    // Row count limit of a pattern, and order table size limit.
    localparam logic [8:0] MAX_ROWS      = 9'd256;
    localparam logic [8:0] MAX_ORDER_LEN = 9'd256;

    // Command codes carried in the command field of a request.
    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_BREAK   = 3'd1;
    localparam logic [2:0] CMD_LOOP    = 3'd2;
    localparam logic [2:0] CMD_ADVANCE = 3'd3;
    localparam logic [2:0] CMD_PEEK    = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ORDER_LENGTH     = 2'd0;
    localparam logic [1:0] CFG_RESTART_POSITION = 2'd1;
    localparam logic [1:0] CFG_HOLD_PATTERN     = 2'd2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;

    // Break parameter decoding: high nibble is tens, low nibble is units.
    localparam logic [3:0] NIBBLE_MASK = 4'hF;
    localparam logic [7:0] BCD_TENS    = 8'd10;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] param;
        logic [8:0] pattern_length;
        logic [7:0] start_row;
        logic [7:0] start_position;
        logic       repeat_song;
    } t_req;

    typedef struct packed {
        logic [7:0] next_row;
        logic [7:0] next_position;
        logic       song_finished;
        logic       pattern_changed;
    } t_rsp;

    // Playback state of the sequencer.
    typedef struct packed {
        logic [7:0] current_row;
        logic [7:0] current_position;
        logic [7:0] loop_start_row;
        logic [3:0] loop_remaining;
        logic       loop_jump_pending;
        logic       break_pending;
        logic [7:0] break_target_row;
        logic       song_repeat;
        logic       is_playing;
    } t_seq_state;

    // Configuration seen by the next-position logic.
    typedef struct packed {
        logic [8:0] order_length;
        logic [7:0] restart_position;
        logic       hold_pattern;
    } t_seq_cfg;

    // Outcome of the next-position computation.
    typedef struct packed {
        logic [7:0] row;
        logic [7:0] position;
        logic       finished;
        logic       took_break;
    } t_next;

endpackage

// File: design/tsps_req_if.sv
// Request channel of the song position sequencer: valid, ready and payload.
// Depends on tsps_pkg for the payload type.
interface tsps_req_if;
    logic          valid;
    logic          ready;
    tsps_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/tsps_rsp_if.sv
// Response channel of the song position sequencer: valid, ready and payload.
// Depends on tsps_pkg for the payload type.
interface tsps_rsp_if;
    logic          valid;
    logic          ready;
    tsps_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/tsps_next.sv
// Next row and order position logic of the song position sequencer.
// Depends on tsps_pkg for the state, configuration and result types.
module tsps_next (
    input  tsps_pkg::t_seq_state i_state,
    input  tsps_pkg::t_seq_cfg   i_cfg,
    input  logic [8:0]           i_pattern_length,
    output tsps_pkg::t_next      o_next
);
    import tsps_pkg::*;

    logic [8:0] plen;
    logic [8:0] olen;
    logic [8:0] pos_inc;
    logic [8:0] row_inc;
    logic       wrapped;
    logic [7:0] follow_pos;
    logic       at_end;

    assign plen       = (i_pattern_length > MAX_ROWS) ? MAX_ROWS : i_pattern_length;
    assign olen       = (i_cfg.order_length > MAX_ORDER_LEN) ? MAX_ORDER_LEN
                                                             : i_cfg.order_length;
    assign pos_inc    = {1'b0, i_state.current_position} + 9'd1;
    assign row_inc    = {1'b0, i_state.current_row} + 9'd1;
    assign wrapped    = !(pos_inc < olen);
    assign follow_pos = wrapped ? i_cfg.restart_position : pos_inc[7:0];
    assign at_end     = (row_inc >= plen);

    always_comb begin
        o_next.row        = i_state.current_row;
        o_next.position   = i_state.current_position;
        o_next.finished   = 1'b0;
        o_next.took_break = 1'b0;
        if (i_state.loop_jump_pending) begin
            o_next.row = i_state.loop_start_row;
        end else if (i_state.break_pending) begin
            o_next.row        = i_state.break_target_row;
            o_next.position   = follow_pos;
            o_next.took_break = 1'b1;
        end else if (at_end) begin
            if (!i_cfg.hold_pattern && wrapped && !i_state.song_repeat) begin
                // Song is over: row and position stay where they are.
                o_next.finished = 1'b1;
            end else begin
                if (!i_cfg.hold_pattern) begin
                    o_next.position = follow_pos;
                end
                o_next.row = 8'd0;
            end
        end else begin
            o_next.row = row_inc[7:0];
        end
    end
endmodule

// File: design/tracker_song_position_sequencer.sv
// Top level of the tracker song position sequencer.
// Depends on tsps_pkg, the tsps_req_if and tsps_rsp_if channels and tsps_next.

// The sequencer keeps the playing row and order position of a module song and
// answers each request with exactly one response. A request is taken at the
// rising edge where i_req.valid and i_req.ready are both high; the playback
// state is updated at that same edge and the response appears in the output
// register on the following cycle, so while i_req.ready stays high the block
// takes one request per cycle. The only stored elements in the path
// are the configuration, state and response registers; the next-position logic
// between them is a couple of 9-bit increments and compares plus a priority
// select. i_req.ready stays high while the response register is empty or is
// being drained in the same cycle, so a held response stalls new requests only
// when the downstream side is not ready. Start requests place playback at a
// row and position; break and loop requests record per-row effects; an advance
// request commits the next row and position and clears the per-row flags; a
// peek request returns the same answer without changing anything. While
// playback is stopped, advance and peek report the current row and position
// with the finished flag set. Configuration writes through i_cfg_we take
// effect at the write edge and are meant to happen while the block is idle.
module tracker_song_position_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tsps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tsps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tsps_req_if.sink                     i_req,
    tsps_rsp_if.source                   o_rsp
);
    import tsps_pkg::*;

    // Configuration registers.
    t_seq_cfg   r_cfg;

    // Playback state and its next value.
    t_seq_state r_state;
    t_seq_state n_state;

    // Response register.
    logic       r_rsp_valid;
    t_rsp       r_rsp;
    t_rsp       n_rsp;

    t_next      nxt;
    logic       accept;
    logic [3:0] loop_nib;
    logic [3:0] loop_dec;
    logic [3:0] brk_hi;
    logic [3:0] brk_lo;
    logic [7:0] brk_row;

    // The response register is free when empty or when it drains this cycle.
    assign i_req.ready   = !r_rsp_valid || o_rsp.ready;
    assign accept        = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    tsps_next u_next (
        .i_state          (r_state),
        .i_cfg            (r_cfg),
        .i_pattern_length (i_req.payload.pattern_length),
        .o_next           (nxt)
    );

    // Break row is taken as tens in the high nibble and units in the low one,
    // wrapped to eight bits.
    assign brk_hi  = i_req.payload.param[7:4];
    assign brk_lo  = i_req.payload.param[3:0] & NIBBLE_MASK;
    assign brk_row = ({4'd0, brk_hi} * BCD_TENS) + {4'd0, brk_lo};

    assign loop_nib = i_req.payload.param[3:0] & NIBBLE_MASK;
    assign loop_dec = r_state.loop_remaining - 4'd1;

    always_comb begin
        n_state = r_state;
        n_rsp   = '0;
        case (i_req.payload.command)
            CMD_START: begin
                n_state.current_row       = i_req.payload.start_row;
                n_state.current_position  = i_req.payload.start_position;
                n_state.song_repeat       = i_req.payload.repeat_song;
                n_state.loop_start_row    = 8'd0;
                n_state.loop_remaining    = 4'd0;
                n_state.loop_jump_pending = 1'b0;
                n_state.break_pending     = 1'b0;
                n_state.break_target_row  = 8'd0;
                n_state.is_playing        = 1'b1;
            end
            CMD_BREAK: begin
                n_state.break_target_row = brk_row;
                n_state.break_pending    = 1'b1;
            end
            CMD_LOOP: begin
                if (loop_nib == 4'd0) begin
                    // A zero count marks the current row as the loop start.
                    n_state.loop_start_row = r_state.current_row;
                end else if (r_state.loop_remaining != 4'd0) begin
                    n_state.loop_remaining = loop_dec;
                    if (loop_dec == 4'd0) begin
                        n_state.loop_start_row = 8'd0;
                    end else begin
                        n_state.loop_jump_pending = 1'b1;
                    end
                end else begin
                    n_state.loop_remaining    = loop_nib;
                    n_state.loop_jump_pending = 1'b1;
                end
            end
            CMD_ADVANCE: begin
                if (r_state.is_playing) begin
                    n_state.current_row       = nxt.row;
                    n_state.current_position  = nxt.position;
                    n_state.loop_jump_pending = 1'b0;
                    n_state.break_pending     = 1'b0;
                    if (nxt.finished) begin
                        n_state.is_playing = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        // Response: advance and peek report the computed next position while playing;
        // everything else reports the position after its own update.
        if (i_req.payload.command inside {CMD_ADVANCE, CMD_PEEK}) begin
            if (r_state.is_playing) begin
                n_rsp.next_row        = nxt.row;
                n_rsp.next_position   = nxt.position;
                n_rsp.song_finished   = nxt.finished;
                n_rsp.pattern_changed = nxt.took_break || (nxt.row == 8'd0);
            end else begin
                n_rsp.next_row        = r_state.current_row;
                n_rsp.next_position   = r_state.current_position;
                n_rsp.song_finished   = 1'b1;
                n_rsp.pattern_changed = 1'b0;
            end
        end else begin
            n_rsp.next_row      = n_state.current_row;
            n_rsp.next_position = n_state.current_position;
        end
    end

    // Control state: configuration, playback state and response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.order_length        <= 9'd1;
            r_cfg.restart_position    <= 8'd0;
            r_cfg.hold_pattern        <= 1'b0;
            r_state.current_row       <= 8'd0;
            r_state.current_position  <= 8'd0;
            r_state.loop_start_row    <= 8'd0;
            r_state.loop_remaining    <= 4'd0;
            r_state.loop_jump_pending <= 1'b0;
            r_state.break_pending     <= 1'b0;
            r_state.break_target_row  <= 8'd0;
            r_state.song_repeat       <= 1'b1;
            r_state.is_playing        <= 1'b0;
            r_rsp_valid               <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORDER_LENGTH:     r_cfg.order_length     <= i_cfg_data;
                    CFG_RESTART_POSITION: r_cfg.restart_position <= i_cfg_data[7:0];
                    CFG_HOLD_PATTERN:     r_cfg.hold_pattern     <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_state     <= n_state;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Response payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end
endmodule

// File: bench/tsps_position_checker.sv
// Watches the request and response channels of the song position sequencer,
// predicts each response from its own copy of the playback state and compares.
// Depends on tsps_pkg and the tsps_req_if and tsps_rsp_if channels.
module tsps_position_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tsps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tsps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    tsps_req_if                               i_req,
    tsps_rsp_if                               i_rsp,
    output int                                o_fail_count,
    output int                                o_pending
);
    import tsps_pkg::*;

    t_seq_state song;
    t_seq_cfg   cfg;
    t_rsp       awaited_rsp_q[$];

    // Order position after the current one; wraps to the restart position.
    function automatic logic [7:0] order_after(output logic wrapped);
        int olen;
        olen = (cfg.order_length > MAX_ORDER_LEN) ? int'(MAX_ORDER_LEN) : int'(cfg.order_length);
        if (int'(song.current_position) + 1 < olen) begin
            wrapped = 1'b0;
            return song.current_position + 8'd1;
        end
        wrapped = 1'b1;
        return cfg.restart_position;
    endfunction

    // Applies one request to the predicted state and returns its response.
    function automatic t_rsp predict_song_step(t_req r);
        t_rsp       rsp;
        logic [7:0] row;
        logic [7:0] pos;
        logic [7:0] p;
        logic       done;
        logic       brk;
        logic       wrapped;
        int         plen;
        done = 1'b0;
        brk  = 1'b0;
        rsp.pattern_changed = 1'b0;
        case (r.command)
            CMD_START: begin
                song.current_row       = r.start_row;
                song.current_position  = r.start_position;
                song.song_repeat       = r.repeat_song;
                song.loop_start_row    = '0;
                song.loop_remaining    = '0;
                song.loop_jump_pending = 1'b0;
                song.break_pending     = 1'b0;
                song.break_target_row  = '0;
                song.is_playing        = 1'b1;
            end
            CMD_BREAK: begin
                song.break_target_row = 8'(int'(r.param[7:4]) * int'(BCD_TENS)
                                           + int'(r.param[3:0] & NIBBLE_MASK));
                song.break_pending = 1'b1;
            end
            CMD_LOOP: begin
                if ((r.param[3:0] & NIBBLE_MASK) == '0) begin
                    song.loop_start_row = song.current_row;
                end else begin
                    if (song.loop_remaining != '0) begin
                        song.loop_remaining = song.loop_remaining - 4'd1;
                        if (song.loop_remaining == '0) song.loop_start_row = '0;
                    end else begin
                        song.loop_remaining = r.param[3:0];
                    end
                    if (song.loop_remaining != '0) song.loop_jump_pending = 1'b1;
                end
            end
            CMD_ADVANCE, CMD_PEEK: begin
                if (!song.is_playing) begin
                    done = 1'b1;
                end else begin
                    row = song.current_row;
                    pos = song.current_position;
                    if (song.loop_jump_pending) begin
                        row = song.loop_start_row;
                    end else if (song.break_pending) begin
                        row = song.break_target_row;
                        pos = order_after(wrapped);
                        brk = 1'b1;
                    end else begin
                        plen = (r.pattern_length > MAX_ROWS) ? int'(MAX_ROWS)
                                                             : int'(r.pattern_length);
                        if (int'(song.current_row) + 1 >= plen) begin
                            if (!cfg.hold_pattern) begin
                                p = order_after(wrapped);
                                if (wrapped && !song.song_repeat) done = 1'b1;
                                else pos = p;
                            end
                            if (!done) row = '0;
                        end else begin
                            row = song.current_row + 8'd1;
                        end
                    end
                    rsp.pattern_changed = brk || (row == '0);
                    if (r.command == CMD_ADVANCE) begin
                        if (done) song.is_playing = 1'b0;
                        song.current_row       = row;
                        song.current_position  = pos;
                        song.loop_jump_pending = 1'b0;
                        song.break_pending     = 1'b0;
                    end else begin
                        // A peek reports the answer without touching the state.
                        rsp.next_row      = row;
                        rsp.next_position = pos;
                        rsp.song_finished = done;
                        return rsp;
                    end
                end
            end
            default: ;
        endcase
        rsp.next_row      = song.current_row;
        rsp.next_position = song.current_position;
        rsp.song_finished = done;
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            song                  = '0;
            song.song_repeat      = 1'b1;
            cfg                   = '0;
            cfg.order_length      = 9'd1;
            awaited_rsp_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORDER_LENGTH:     cfg.order_length     = i_cfg_data;
                    CFG_RESTART_POSITION: cfg.restart_position = i_cfg_data[7:0];
                    CFG_HOLD_PATTERN:     cfg.hold_pattern     = i_cfg_data[0];
                    default: ;
                endcase
            end
            // Retire the oldest expectation before queuing the one for a new request,
            // so a response can never be matched with the request of its own edge.
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.payload;
                if (awaited_rsp_q.size() == 0) begin
                    $error("response with no request outstanding: row %0d position %0d",
                           got.next_row, got.next_position);
                    o_fail_count++;
                end else begin
                    want = awaited_rsp_q.pop_front();
                    if (got.next_row !== want.next_row) begin
                        $error("next_row: expected %0d, got %0d", want.next_row, got.next_row);
                        o_fail_count++;
                    end
                    if (got.next_position !== want.next_position) begin
                        $error("next_position: expected %0d, got %0d",
                               want.next_position, got.next_position);
                        o_fail_count++;
                    end
                    if (got.song_finished !== want.song_finished) begin
                        $error("song_finished: expected %0d, got %0d",
                               want.song_finished, got.song_finished);
                        o_fail_count++;
                    end
                    if (got.pattern_changed !== want.pattern_changed) begin
                        $error("pattern_changed: expected %0d, got %0d",
                               want.pattern_changed, got.pattern_changed);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_rsp_q.push_back(predict_song_step(i_req.payload));
            end
        end
        o_pending = awaited_rsp_q.size();
    end

endmodule

// File: bench/tb.sv
// Top of the song position sequencer testbench: clock, reset, stimulus and verdict.
// Depends on tsps_pkg, the channel interfaces, tsps_position_checker and the block.
module tb;
    import tsps_pkg::*;

    // Far above the slowest correct run: roughly 1300 requests, each with the
    // longest sender gaps and receiver stalls of the busiest phase.
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 217;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int cycles;
    int requests_sent;
    int sender_idle_pct;
    int receiver_stall_pct;

    tsps_req_if req_ch ();
    tsps_rsp_if rsp_ch ();

    tracker_song_position_sequencer uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    tsps_position_checker position_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The watchdog ends a run that hangs; a correct run never gets near the limit.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver decides at every falling edge whether it takes a response in
    // the next cycle; the stall rate follows the current phase.
    always @(negedge clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    function automatic t_req make_req(logic [2:0] cmd, logic [7:0] param, logic [8:0] plen,
                                      logic [7:0] srow, logic [7:0] spos, logic rep);
        t_req r;
        r.command        = cmd;
        r.param          = param;
        r.pattern_length = plen;
        r.start_row      = srow;
        r.start_position = spos;
        r.repeat_song    = rep;
        return r;
    endfunction

    // One random song event. Fields that the command does not use still carry
    // random bits, so every input bit toggles whatever the command.
    function automatic t_req random_song_event(int plen_now);
        t_req r;
        int   pick;
        r = make_req(CMD_ADVANCE, 8'($urandom), 9'(plen_now), 8'($urandom), 8'($urandom),
                     1'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            r.command = CMD_START;
            // Mostly start inside the pattern, so playback runs for a while.
            if ($urandom_range(0, 99) < 70) begin
                r.start_row = (plen_now > 1) ? 8'($urandom_range(0, (plen_now > 256 ? 256
                                                                    : plen_now) - 1)) : 8'd0;
                r.start_position = 8'($urandom_range(0, 5));
            end
        end else if (pick < 14) begin
            r.command = CMD_BREAK;
        end else if (pick < 26) begin
            r.command = CMD_LOOP;
            if ($urandom_range(0, 2) == 0) r.param[3:0] = '0;
            else r.param[3:0] = 4'($urandom_range(1, 3));
        end else if (pick < 80) begin
            r.command = CMD_ADVANCE;
        end else if (pick < 94) begin
            r.command = CMD_PEEK;
        end else begin
            // Codes past the last defined command leave the block's state unchanged.
            r.command = 3'(CMD_PEEK + $urandom_range(1, 3));
        end
        return r;
    endfunction

    // Presents one request at a falling edge and holds it until it is taken.
    // Valid is lowered only by an idle cycle, never in the step where it rises.
    task automatic issue_request(t_req r);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do @(posedge clk); while (!req_ch.ready);
        if (r.command <= CMD_PEEK) requests_sent++;
    endtask

    // Waits until every expected response has come back, then lets the
    // response register settle before anything else happens.
    task automatic drain_responses();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // A well-formed pattern loop: mark the start, play a few rows, then repeat
    // the loop request until its count runs out, advancing after each one but the last, which may be a peek.
    task automatic pattern_loop_block(int plen);
        t_req r;
        int   reps;
        int   span;
        span = $urandom_range(0, 3);
        reps = $urandom_range(1, 4);
        r = random_song_event(plen);
        r.command = CMD_LOOP;
        r.param[3:0] = '0;
        issue_request(r);
        for (int i = 0; i <= reps; i++) begin
            repeat (span) begin
                r = random_song_event(plen);
                r.command = CMD_ADVANCE;
                issue_request(r);
            end
            r = random_song_event(plen);
            r.command = CMD_LOOP;
            r.param[3:0] = 4'(reps);
            issue_request(r);
            r = random_song_event(plen);
            r.command = (i == reps && $urandom_range(0, 1) == 0) ? CMD_PEEK : CMD_ADVANCE;
            issue_request(r);
        end
    endtask

    initial begin
        t_req r;
        int   pat_len;
        int   pick;
        int   phase_target;
        logic [8:0] order_len_setting [PHASE_COUNT];
        logic [7:0] restart_setting   [PHASE_COUNT];
        logic       hold_setting      [PHASE_COUNT];

        // Order lengths cover the smallest and largest legal tables, a zero
        // length where every entry is the last, and a value above the limit.
        order_len_setting = '{9'd1, 9'd256, 9'd4, 9'd0, 9'd511, 9'd3};
        restart_setting   = '{8'd0, 8'd255, 8'd2, 8'($urandom), 8'd0, 8'd255};
        hold_setting      = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.payload     = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the reset configuration: one order entry,
        // restart at zero and no pattern hold.
        // Advance and peek while playback has never started.
        issue_request(make_req(CMD_ADVANCE, 8'h00, 9'd64, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_PEEK, 8'h00, 9'd64, 8'd0, 8'd0, 1'b0));
        // Break and loop requests still update their state while stopped.
        issue_request(make_req(CMD_BREAK, 8'hFF, 9'd64, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_LOOP, 8'h00, 9'd64, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_LOOP, 8'h0F, 9'd64, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(3'(CMD_PEEK + 3), 8'hFF, 9'h1FF, 8'hFF, 8'hFF, 1'b1));
        // Last row of the last entry without song repeat: the song finishes,
        // and a further advance finds playback stopped.
        issue_request(make_req(CMD_START, 8'h00, 9'd256, 8'd255, 8'd255, 1'b0));
        issue_request(make_req(CMD_PEEK, 8'h00, 9'd256, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_ADVANCE, 8'h00, 9'd256, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_ADVANCE, 8'h00, 9'd256, 8'd0, 8'd0, 1'b0));
        // A zero pattern length ends the pattern on every row; a length above
        // the row limit is clipped to it.
        issue_request(make_req(CMD_START, 8'h00, 9'd16, 8'd0, 8'd0, 1'b1));
        issue_request(make_req(CMD_ADVANCE, 8'h00, 9'd0, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_ADVANCE, 8'h00, 9'h1FF, 8'd0, 8'd0, 1'b0));
        // Break at the last order entry goes to the restart position.
        issue_request(make_req(CMD_BREAK, 8'h99, 9'd16, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_ADVANCE, 8'h00, 9'd16, 8'd0, 8'd0, 1'b0));
        // Loop count of two: two jumps back, then the count runs out.
        issue_request(make_req(CMD_LOOP, 8'hA2, 9'd16, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_ADVANCE, 8'h00, 9'd16, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_LOOP, 8'h52, 9'd16, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_ADVANCE, 8'h00, 9'd16, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_LOOP, 8'h02, 9'd16, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_ADVANCE, 8'h00, 9'd8, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_PEEK, 8'h00, 9'd1, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(3'(CMD_PEEK + 1), 8'h00, 9'd1, 8'd0, 8'd0, 1'b0));
        // Break to row zero reports a pattern change through both causes.
        issue_request(make_req(CMD_BREAK, 8'h00, 9'd16, 8'd0, 8'd0, 1'b0));
        issue_request(make_req(CMD_ADVANCE, 8'h00, 9'd16, 8'd0, 8'd0, 1'b0));

        // Random part. Each phase reconfigures the block while it is idle and
        // uses its own mix of sender gaps and receiver stalls.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            drain_responses();
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
            write_register(CFG_ORDER_LENGTH, order_len_setting[phase]);
            write_register(CFG_RESTART_POSITION, {1'b0, restart_setting[phase]});
            write_register(CFG_HOLD_PATTERN, {8'd0, hold_setting[phase]});
            case (phase % 4)
                1:       sender_idle_pct = 75;
                2:       receiver_stall_pct = 75;
                3: begin
                    sender_idle_pct    = 37;
                    receiver_stall_pct = 37;
                end
                default: ;
            endcase
            pat_len = $urandom_range(1, 8);
            phase_target = requests_sent + PHASE_ITEMS;
            // Every phase opens with a start so the song is actually playing.
            r = random_song_event(pat_len);
            r.command = CMD_START;
            r.start_row = '0;
            issue_request(r);
            while (requests_sent < phase_target) begin
                // Short patterns reach the pattern end often; some take longer
                // lengths up to the largest size, and a few any 9-bit length.
                if ($urandom_range(0, 9) == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 85) pat_len = $urandom_range(1, 8);
                    else if (pick < 95) pat_len = $urandom_range(9, 256);
                    else pat_len = $urandom_range(0, 511);
                end
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    pattern_loop_block(pat_len);
                end else if (pick < 25) begin
                    r = random_song_event(pat_len);
                    r.command = CMD_BREAK;
                    issue_request(r);
                    r = random_song_event(pat_len);
                    r.command = CMD_ADVANCE;
                    issue_request(r);
                end else begin
                    issue_request(random_song_event(pat_len));
                end
            end
        end

        drain_responses();
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
design/tsps_pkg.sv
design/tsps_req_if.sv
design/tsps_rsp_if.sv
design/tsps_next.sv
design/tracker_song_position_sequencer.sv
bench/tsps_position_checker.sv
bench/tb.sv
